// ===== rtl/efg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package efg_pkg;

    // Operation codes carried on the slave tuser
    typedef logic [1:0] func_t;
    localparam func_t FUNC_CREATE = 2'd0;
    localparam func_t FUNC_SET    = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;
    localparam func_t FUNC_WAIT   = 2'd3;

    // Wait modes; the two upper codes never match
    typedef logic [1:0] wait_mode_t;
    localparam wait_mode_t WAIT_ALL = 2'd0;
    localparam wait_mode_t WAIT_ANY = 2'd1;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t STAT_OK      = 3'd0;
    localparam status_t STAT_BADID   = 3'd1;
    localparam status_t STAT_NOEXIST = 3'd2;
    localparam status_t STAT_LIMIT   = 3'd3;
    localparam status_t STAT_TMOUT   = 3'd4;
    localparam status_t STAT_BLOCK   = 3'd5;

    localparam int ID_W      = 8;
    localparam int NEW_ID_W  = 5;
    localparam int FLAG_W    = 32;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 40;

    // One result word
    typedef struct packed {
        logic [FLAG_W-1:0]   pattern_out;
        logic [NEW_ID_W-1:0] new_id;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/efg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efg_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_W-1:0]    raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/event_flag_table_top.sv =====
// Each accepted word is read from the flag RAM at accept, then takes the
// read-modify-write state for the modify and write-back; the result word is
// registered on the master side. A new word is taken only in the idle state.
// A result held by a stalled master side holds the read-modify-write state until taken.
// Reset (rst_n low, asynchronous) frees all slots and empties the output
// register; flag words are not cleared and are written by create before use.
`timescale 1ns / 1ps
`default_nettype none

module event_flag_table_top #(
    parameter int unsigned SLOT_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] flag_id, [39:8] pattern, [41:40] wait_mode, [42] poll_only, rest zero
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [7:3] new_id, [39:8] pattern_out
    output logic [39:0]      m_axis_tdata
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RMW  = 1'b1;

    // Input word fields
    logic [efg_pkg::ID_W-1:0]   in_id;
    logic [efg_pkg::FLAG_W-1:0] in_pattern;
    logic [7:0]                 in_id_m1;
    logic                       in_id_ok;
    logic                       accept;

    assign in_id      = s_axis_tdata[7:0];
    assign in_pattern = s_axis_tdata[39:8];
    assign in_id_m1   = in_id - 8'd1;
    assign in_id_ok   = (in_id != 8'd0) && ({1'b0, in_id} <= SLOT_LIMIT);

    // Control and captured request
    logic                       state_reg, state_next;
    logic [SLOT_COUNT-1:0]      in_use_reg, in_use_next;
    logic [SLOT_W-1:0]          free_idx_reg, free_idx_next;
    logic                       free_found_reg, free_found_next;
    logic                       m_valid_reg, m_valid_next;
    efg_pkg::result_t           result_reg, result_next;

    efg_pkg::func_t             func_reg;
    logic                       id_ok_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [efg_pkg::FLAG_W-1:0] pattern_reg;
    efg_pkg::wait_mode_t        mode_reg;
    logic                       poll_reg;

    // RAM port signals
    logic                       ram_we;
    logic [SLOT_W-1:0]          ram_waddr;
    logic [efg_pkg::FLAG_W-1:0] ram_wdata;
    logic [efg_pkg::FLAG_W-1:0] ram_rdata;

    logic                       finish;
    logic                       slot_used;
    logic                       match;
    logic [8:0]                 id_sum;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = result_reg;

    // Flag words live in RAM; read at accept, written back at finish.
    // A read is issued only in the idle state, after the previous write-back, so no forwarding.
    efg_ram #(
        .WIDTH (efg_pkg::FLAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_flag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_id_m1[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Lowest free slot, registered; in_use settles before any create uses it
    always_comb
    begin
        free_idx_next   = '0;
        free_found_next = 1'b0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--)
        begin
            if (!in_use_reg[k])
            begin
                free_idx_next   = SLOT_W'(k);
                free_found_next = 1'b1;
            end
        end
    end

    // Read-modify-write step
    always_comb
    begin
        state_next   = state_reg;
        in_use_next  = in_use_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = ram_rdata;
        id_sum       = 9'(free_idx_reg) + 9'd1;
        slot_used    = id_ok_reg ? in_use_reg[slot_reg] : 1'b0;
        finish       = (state_reg == ST_RMW) && (!m_valid_reg || m_axis_tready);

        case (mode_reg)
            efg_pkg::WAIT_ALL: match = ((ram_rdata & pattern_reg) == pattern_reg);
            efg_pkg::WAIT_ANY: match = ((ram_rdata & pattern_reg) != '0);
            default:           match = 1'b0;
        endcase

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (finish)
        begin
            state_next          = ST_IDLE;
            m_valid_next        = 1'b1;
            result_next.status      = efg_pkg::STAT_OK;
            result_next.new_id      = '0;
            result_next.pattern_out = '0;

            if (func_reg == efg_pkg::FUNC_CREATE)
            begin
                if (free_found_reg)
                begin
                    in_use_next[free_idx_reg] = 1'b1;
                    ram_we                    = 1'b1;
                    ram_waddr                 = free_idx_reg;
                    ram_wdata                 = pattern_reg;
                    result_next.new_id        = id_sum[efg_pkg::NEW_ID_W-1:0];
                end
                else
                begin
                    result_next.status = efg_pkg::STAT_LIMIT;
                end
            end
            else if (!id_ok_reg)
            begin
                result_next.status = efg_pkg::STAT_BADID;
            end
            else if (!slot_used)
            begin
                result_next.status = efg_pkg::STAT_NOEXIST;
            end
            else
            begin
                case (func_reg)
                    efg_pkg::FUNC_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | pattern_reg;
                    end
                    efg_pkg::FUNC_CLEAR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~pattern_reg;
                    end
                    default:
                    begin
                        if (match)
                        begin
                            ram_we                  = 1'b1;
                            ram_wdata               = ram_rdata & ~pattern_reg;
                            result_next.pattern_out = ram_rdata;
                        end
                        else if (poll_reg)
                        begin
                            result_next.status = efg_pkg::STAT_TMOUT;
                        end
                        else
                        begin
                            result_next.status = efg_pkg::STAT_BLOCK;
                        end
                    end
                endcase
            end
        end
        else if (accept)
        begin
            state_next = ST_RMW;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            free_idx_reg   <= free_idx_next;
            free_found_reg <= free_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            func_reg    <= s_axis_tuser;
            id_ok_reg   <= in_id_ok;
            slot_reg    <= in_id_m1[SLOT_W-1:0];
            pattern_reg <= in_pattern;
            mode_reg    <= s_axis_tdata[41:40];
            poll_reg    <= s_axis_tdata[42];
        end
    end

`ifndef NO_ASSERTIONS
    // A slot once taken is never freed
    assert property (@(posedge clk) disable iff (!rst_n)
        (($past(in_use_reg) & ~in_use_reg) == '0))
        else $error("in-use slot was freed");

    // At most one slot is claimed per word
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(in_use_reg ^ $past(in_use_reg)) <= 1))
        else $error("more than one slot claimed at once");

    // Flag RAM is written only when a word finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> finish)
        else $error("flag RAM written outside finish");

    // A new id comes only with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (result_reg.new_id == '0 || result_reg.status == efg_pkg::STAT_OK))
        else $error("new id with error status");

    // An accepted word always enters the read-modify-write state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RMW))
        else $error("accepted word not processed");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_event_flag_table_top.sv =====
`timescale 1ns / 1ps

module tb_event_flag_table_top;

    localparam int SLOT_COUNT  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 900;
    localparam int TAIL_CYCLES = 8;

    // Predicts the flag table and checks each result word against it
    class flag_table_scoreboard;
        bit               slot_used [SLOT_COUNT];
        logic [31:0]      flag_word [SLOT_COUNT];
        efg_pkg::result_t expected_results [$];
        int               mismatches;

        function new();
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_used[k] = 1'b0;
                flag_word[k] = '0;
            end
            mismatches = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            mismatches++;
        endtask

        // Apply one accepted request to the table copy and queue its result
        function void predict_request(efg_pkg::func_t func, logic [7:0] id,
                                      logic [31:0] pat, efg_pkg::wait_mode_t mode,
                                      logic poll);
            efg_pkg::result_t want;
            int               slot;
            bit               hit;
            want = '0;
            slot = int'(id) - 1;
            if (func == efg_pkg::FUNC_CREATE)
            begin
                want.status = efg_pkg::STAT_LIMIT;
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    if (!slot_used[k])
                    begin
                        slot_used[k] = 1'b1;
                        flag_word[k] = pat;
                        want.status  = efg_pkg::STAT_OK;
                        want.new_id  = efg_pkg::NEW_ID_W'(k + 1);
                        break;
                    end
                end
            end
            else if (id == 0 || id > SLOT_COUNT)
                want.status = efg_pkg::STAT_BADID;
            else if (!slot_used[slot])
                want.status = efg_pkg::STAT_NOEXIST;
            else
            begin
                case (func)
                    efg_pkg::FUNC_SET:   flag_word[slot] |= pat;
                    efg_pkg::FUNC_CLEAR: flag_word[slot] &= ~pat;
                    default:
                    begin
                        case (mode)
                            efg_pkg::WAIT_ALL: hit = (flag_word[slot] & pat) == pat;
                            efg_pkg::WAIT_ANY: hit = |(flag_word[slot] & pat);
                            default:           hit = 1'b0;
                        endcase
                        if (hit)
                        begin
                            want.pattern_out = flag_word[slot];
                            flag_word[slot] &= ~pat;
                        end
                        else
                            want.status = poll ? efg_pkg::STAT_TMOUT : efg_pkg::STAT_BLOCK;
                    end
                endcase
            end
            expected_results.push_back(want);
        endfunction

        task check_result(efg_pkg::result_t got);
            efg_pkg::result_t want;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result word", 32'(got), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.new_id !== want.new_id)
                    report_mismatch("new_id", 32'(got.new_id), 32'(want.new_id));
                if (got.pattern_out !== want.pattern_out)
                    report_mismatch("pattern_out", got.pattern_out, want.pattern_out);
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    flag_table_scoreboard sb;
    int burst_left;
    int cycle_count;

    event_flag_table_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit guards against a hung handshake
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: phases of always ready, coin flip, mostly stalled and periodic
    initial
    begin
        int kind;
        int span;
        int step;
        m_axis_tready = 1'b0;
        step = 0;
        forever
        begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                step++;
                case (kind)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= (step % 3 == 0);
                endcase
            end
        end
    end

    // Result words are checked at the rising edge they are taken
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(efg_pkg::result_t'(m_axis_tdata));
    end

    // Drive one request word and hold it until taken; called at a falling edge
    task automatic send_request(efg_pkg::func_t func, logic [7:0] id, logic [31:0] pat,
                                efg_pkg::wait_mode_t mode, logic poll);
        int gap;
        s_axis_tdata  <= {5'd0, poll, mode, pat, id};
        s_axis_tuser  <= func;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.predict_request(func, id, pat, mode, poll);
        @(negedge clk);
        // bursts of random length, random gaps between them
        burst_left--;
        if (burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_all_results();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Random request, biased toward in-range ids and patterns drawn from the live word
    task automatic random_request(output efg_pkg::func_t func, output logic [7:0] id,
                                  output logic [31:0] pat,
                                  output efg_pkg::wait_mode_t mode,
                                  output logic poll);
        int          pick;
        logic [31:0] live;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            func = efg_pkg::FUNC_CREATE;
        else if (pick < 30)
            func = efg_pkg::FUNC_SET;
        else if (pick < 50)
            func = efg_pkg::FUNC_CLEAR;
        else
            func = efg_pkg::FUNC_WAIT;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            id = 8'd0;
        else if (pick == 1)
            id = 8'($urandom_range(SLOT_COUNT + 1, 255));
        else
            id = 8'($urandom_range(1, SLOT_COUNT));
        live = (id >= 1 && id <= SLOT_COUNT) ? sb.flag_word[id - 1] : $urandom;
        case ($urandom_range(0, 5))
            0:       pat = $urandom;
            1:       pat = 32'd1 << $urandom_range(0, 31);
            2, 3:    pat = live & $urandom;
            4:       pat = $urandom & $urandom;
            default: pat = live | (32'd1 << $urandom_range(0, 31));
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 9)
            mode = efg_pkg::WAIT_ALL;
        else if (pick < 18)
            mode = efg_pkg::WAIT_ANY;
        else
            mode = efg_pkg::wait_mode_t'($urandom_range(2, 3));
        poll = 1'($urandom_range(0, 1));
    endtask

    initial
    begin
        efg_pkg::func_t      func;
        logic [7:0]          id;
        logic [31:0]         pat;
        efg_pkg::wait_mode_t mode;
        logic                poll;

        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = $urandom_range(1, 40);
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: errors on an empty table, both creates, every wait outcome
        send_request(efg_pkg::FUNC_SET,    8'd1,   32'h0000_0001, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_WAIT,   8'd0,   32'h0000_0001, efg_pkg::WAIT_ALL, 1'b1);
        send_request(efg_pkg::FUNC_CLEAR,  8'd17,  32'hFFFF_FFFF, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_CREATE, 8'd0,   32'hFFFF_FFFF, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_CREATE, 8'd255, 32'h0000_0000, efg_pkg::WAIT_ANY, 1'b1);
        send_request(efg_pkg::FUNC_SET,    8'd2,   32'h8000_0001, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_CLEAR,  8'd1,   32'h0000_FFFF, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_WAIT,   8'd1,   32'hFFFF_0000, efg_pkg::WAIT_ALL, 1'b0);
        // empty pattern: all-bits mode matches, any-bit mode never does
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'h0000_0000, efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'h0000_0000, efg_pkg::WAIT_ANY, 1'b1);
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'h0000_0001, efg_pkg::WAIT_ANY, 1'b0);
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'hC000_0000, efg_pkg::WAIT_ALL, 1'b1);
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'hC000_0000, efg_pkg::WAIT_ALL, 1'b0);
        // undefined modes never match
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'h8000_0000,
                     efg_pkg::wait_mode_t'(2), 1'b0);
        send_request(efg_pkg::FUNC_WAIT,   8'd2,   32'h8000_0000,
                     efg_pkg::wait_mode_t'(3), 1'b1);
        send_request(efg_pkg::FUNC_WAIT,   8'd255, 32'h8000_0000, efg_pkg::WAIT_ANY, 1'b1);
        send_request(efg_pkg::FUNC_CLEAR,  8'd16,  32'h0000_0001, efg_pkg::WAIT_ALL, 1'b0);
        // fill the table, then one more create hits the limit
        repeat (SLOT_COUNT - 2)
            send_request(efg_pkg::FUNC_CREATE, 8'($urandom), $urandom,
                         efg_pkg::WAIT_ALL, 1'b0);
        send_request(efg_pkg::FUNC_CREATE, 8'd1, 32'h1234_5678, efg_pkg::WAIT_ALL, 1'b0);
        wait_all_results();

        // Random traffic with one full drain midway
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                wait_all_results();
            random_request(func, id, pat, mode, poll);
            send_request(func, id, pat, mode, poll);
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/efg_pkg.sv
rtl/efg_ram.sv
rtl/event_flag_table_top.sv
tb/sv/tb_event_flag_table_top.sv
